// ===== design/oets_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odd-even transposition sort package
// Shared word type, pad value and cell command codes.
// ----------------------------------------------------------------------------
package oets_pkg;

	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	// Largest positive word; it fills every slot that holds no loaded word.
	localparam word_t PAD_WORD = 32'sh7FFF_FFFF;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_LOAD,
		CMD_SHIFT,
		CMD_CMP_RIGHT,
		CMD_CMP_LEFT
	} cell_cmd_t;

endpackage
`default_nettype wire

// ===== design/odd_even_transposition_sort_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odd-even transposition sort core
// Loads a set of signed words, sorts them in a row of cells, emits them.
// ----------------------------------------------------------------------------
// A set is written one word per accepted start (start high while busy is
// low), the final word marked by in_last; busy stays low between loads.
// After the last word, busy rises: the cell row runs one odd-even
// transposition phase per cycle, up to DEPTH + 2 phases, ending after two
// phases in a row without a swap. The sorted words then leave in ascending
// order, one per cycle on out_value with out_valid high for exactly one
// cycle each, out_last on the final one, through a single output register.
// The receiver cannot stall, so it must take a word in every cycle in which
// out_valid is high. A set of n words therefore takes n loads, at most
// DEPTH + 2 sort phases and n emissions, in a row of DEPTH cells with one
// compare per pair. Words beyond DEPTH in one set are dropped, though a
// dropped word marked last still ends the set.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort_core
	import oets_pkg::*;
#(
	parameter int DEPTH = 64
)(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire signed [31:0] in_value,
	input  wire               in_last,
	output logic              out_valid,
	output logic signed [31:0] out_value,
	output logic              out_last
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   emit_q;
	logic               parity_q;
	logic [1:0]         quiet_q;
	word_t              result_q;
	logic               result_last_q;
	logic               result_valid_q;

	word_t              cell_value [DEPTH];
	logic [DEPTH-1:0]   cell_swap;
	logic               accept;
	logic               any_swap;
	logic               emit_final;

	assign busy       = (state_q != ST_LOAD);
	assign accept     = start && !busy;
	assign any_swap   = |cell_swap;
	assign emit_final = ((emit_q + CNT_W'(1)) == count_q);

	// The cell row: each cell pairs with the neighbor chosen by the phase
	// parity, and during emission every cell takes its upper neighbor's word.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam bit ODD = (i % 2) == 1;
		cell_cmd_t cmd;
		word_t     left_word;
		word_t     right_word;

		if (i == 0) begin : g_left_edge
			assign left_word = PAD_WORD;
		end else begin : g_left
			assign left_word = cell_value[i-1];
		end

		if (i == DEPTH - 1) begin : g_right_edge
			assign right_word = PAD_WORD;
		end else begin : g_right
			assign right_word = cell_value[i+1];
		end

		always_comb begin
			cmd = CMD_HOLD;
			case (state_q)
				ST_LOAD: begin
					if (accept && (count_q == CNT_W'(i))) begin
						cmd = CMD_LOAD;
					end
				end
				ST_SORT: begin
					if ((parity_q == ODD) && (i + 1 < DEPTH)) begin
						cmd = CMD_CMP_RIGHT;
					end else if ((parity_q != ODD) && (i > 0)) begin
						cmd = CMD_CMP_LEFT;
					end
				end
				ST_EMIT: cmd = CMD_SHIFT;
				default: cmd = CMD_HOLD;
			endcase
		end

		oets_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.load_value  (in_value),
			.left_value  (left_word),
			.right_value (right_word),
			.value       (cell_value[i]),
			.swap        (cell_swap[i])
		);
	end

	// Sequencer: counts the loaded words, runs the phases until two quiet
	// ones in a row, then shifts the row out through the output register.
	// Shifting pads in from the top, so the row is all pad after a set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			count_q        <= '0;
			emit_q         <= '0;
			parity_q       <= 1'b0;
			quiet_q        <= 2'd0;
			result_valid_q <= 1'b0;
			result_last_q  <= 1'b0;
			result_q       <= PAD_WORD;
		end else begin
			result_valid_q <= (state_q == ST_EMIT);
			result_last_q  <= (state_q == ST_EMIT) && emit_final;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (count_q != CNT_W'(DEPTH)) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (in_last) begin
							state_q  <= ST_SORT;
							parity_q <= 1'b0;
							quiet_q  <= 2'd0;
						end
					end
				end
				ST_SORT: begin
					parity_q <= !parity_q;
					if (any_swap) begin
						quiet_q <= 2'd0;
					end else begin
						quiet_q <= quiet_q + 2'd1;
						if (quiet_q == 2'd1) begin
							state_q <= ST_EMIT;
							emit_q  <= '0;
						end
					end
				end
				ST_EMIT: begin
					result_q <= cell_value[0];
					if (emit_final) begin
						state_q  <= ST_LOAD;
						count_q  <= '0;
						emit_q   <= '0;
						parity_q <= 1'b0;
						quiet_q  <= 2'd0;
					end else begin
						emit_q <= emit_q + CNT_W'(1);
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_valid = result_valid_q;
	assign out_value = result_q;
	assign out_last  = result_last_q;

	// A word only leaves in the cycle after an emission step.
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($past(state_q) == ST_EMIT))
		else $error("result word without an emission step");

	// The loaded count saturates at the row length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("word count beyond row length");

	// Words of one set leave in ascending signed order.
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $past(out_valid) && !$past(out_last))
			|-> (out_value >= $past(out_value)))
		else $error("emitted words out of order");

	// The final word of a set returns the block to loading.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |-> (state_q == ST_LOAD && count_q == '0))
		else $error("block still busy after the final word");

endmodule
`default_nettype wire

// ===== design/oets_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odd-even transposition sort cell
// Holds one word and exchanges it with a neighbor on command.
// ----------------------------------------------------------------------------
module oets_cell
	import oets_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  cell_cmd_t  cmd,
	input  word_t      load_value,
	input  word_t      left_value,
	input  word_t      right_value,
	output word_t      value,
	output logic       swap
);

	word_t value_q;
	word_t value_d;

	always_comb begin
		value_d = value_q;
		swap    = 1'b0;
		case (cmd)
			CMD_LOAD:  value_d = load_value;
			CMD_SHIFT: value_d = right_value;
			CMD_CMP_RIGHT: begin
				// Lower cell of a pair keeps the smaller word.
				if (value_q > right_value) begin
					value_d = right_value;
					swap    = 1'b1;
				end
			end
			CMD_CMP_LEFT: begin
				// Upper cell of a pair keeps the larger word.
				if (left_value > value_q) begin
					value_d = left_value;
				end
			end
			default: value_d = value_q;
		endcase
	end

	// Cells come out of reset padded so that a set never sees stale words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= PAD_WORD;
		end else begin
			value_q <= value_d;
		end
	end

	assign value = value_q;

endmodule
`default_nettype wire

// ===== tb/sv/oets_sort_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odd-even transposition sort checker
// Watches the load and emit channels of the sort core, predicts each sorted
// set from the loaded words and compares every emitted word with it.
// ----------------------------------------------------------------------------
module oets_sort_checker
	import oets_pkg::*;
#(
	parameter int DEPTH = 64
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  word_t       in_value,
	input  logic        in_last,
	input  logic        out_valid,
	input  word_t       out_value,
	input  logic        out_last,
	output int          mismatches,
	output int          words_due
);

	typedef struct {
		word_t value;
		logic  last;
	} sorted_word_t;

	sorted_word_t sorted_words_due[$];
	word_t        slots [DEPTH];
	int           loaded;
	int           fail_total;

	initial begin
		loaded     = 0;
		fail_total = 0;
		mismatches = 0;
		words_due  = 0;
	end

	// Pads the row, runs transposition phases until two quiet ones in a row,
	// then queues the loaded words in their sorted order.
	task automatic sort_loaded_set();
		int           parity;
		int           quiet;
		int           i;
		bit           swapped;
		word_t        tmp;
		sorted_word_t w;
		for (i = loaded; i < DEPTH; i++)
			slots[i] = PAD_WORD;
		parity = 0;
		quiet  = 0;
		while (quiet < 2) begin
			swapped = 1'b0;
			for (i = parity; i + 1 < DEPTH; i += 2) begin
				if (slots[i] > slots[i+1]) begin
					tmp        = slots[i];
					slots[i]   = slots[i+1];
					slots[i+1] = tmp;
					swapped    = 1'b1;
				end
			end
			quiet  = swapped ? 0 : quiet + 1;
			parity = parity ^ 1;
		end
		for (i = 0; i < loaded; i++) begin
			w.value = slots[i];
			w.last  = (i == loaded - 1);
			sorted_words_due.push_back(w);
		end
		loaded = 0;
	endtask

	always @(posedge clk) begin
		sorted_word_t head;
		if (!arst_n) begin
			loaded = 0;
			sorted_words_due.delete();
		end else begin
			// Emitted words are matched before a new set is predicted.
			if (out_valid) begin
				if (sorted_words_due.size() == 0) begin
					$error("unexpected word: out_value %0d out_last %0b", out_value, out_last);
					fail_total++;
				end else begin
					head = sorted_words_due.pop_front();
					if (out_value !== head.value) begin
						$error("out_value mismatch: expected %0d, actual %0d",
							head.value, out_value);
						fail_total++;
					end
					if (out_last !== head.last) begin
						$error("out_last mismatch: expected %0b, actual %0b",
							head.last, out_last);
						fail_total++;
					end
				end
			end
			if (start && !busy) begin
				// A full row drops the word, but a last mark still ends the set.
				if (loaded < DEPTH) begin
					slots[loaded] = in_value;
					loaded++;
				end
				if (in_last)
					sort_loaded_set();
			end
		end
		mismatches <= fail_total;
		words_due  <= sorted_words_due.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odd-even transposition sort core testbench
// Loads directed and random sets of signed words, with random sender gaps,
// and lets the checker compare every emitted word with its prediction.
// ----------------------------------------------------------------------------
module tb;
	import oets_pkg::*;

	localparam int DEPTH        = 64;
	localparam int RANDOM_ITEMS = 200;
	// Longest random gap the sender may insert before one word.
	localparam int MAX_GAP      = 40;
	// A correct run never goes this long without taking or emitting a word:
	// the worst case is a gap plus a full sort of DEPTH + 2 phases.
	localparam int STALL_LIMIT  = 1000;
	// Cycles to keep watching after the last expected word, long enough for
	// a spurious set to be sorted and emitted.
	localparam int TAIL_CYCLES  = 2 * DEPTH + 16;
	localparam word_t MIN_WORD  = 32'sh8000_0000;
	// Percent of cycles in which the sender idles, one entry per phase. The
	// receiver cannot hold results off, so its phases idle only the sender.
	localparam int IDLE_PCT [4] = '{0, 74, 0, 27};

	logic  clk      = 1'b0;
	logic  arst_n   = 1'b0;
	logic  start    = 1'b0;
	word_t in_value = '0;
	logic  in_last  = 1'b0;
	logic  busy;
	logic  out_valid;
	word_t out_value;
	logic  out_last;

	int mismatches;
	int words_due;
	int idle_pct = 0;

	odd_even_transposition_sort_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.in_value (in_value),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_value(out_value),
		.out_last (out_last)
	);

	oets_sort_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_value  (in_value),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_value (out_value),
		.out_last  (out_last),
		.mismatches(mismatches),
		.words_due (words_due)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Offers one word and returns at the clock edge that accepts it. The
	// start line is left high, so the next call can offer its word in the
	// same time step without lowering start first. When a gap is drawn,
	// start drops for that many cycles, which also lands gaps on the sort
	// and emit phases when the previous word closed a set.
	task automatic send_word(input word_t value, input logic last);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		in_value <= value;
		in_last  <= last;
		// busy is sampled as it was before the edge, so a low busy here
		// means the word was taken at this edge.
		do @(posedge clk); while (busy);
	endtask

	// Sends a whole set, marking its final word as last.
	task automatic send_set(input word_t set_words[$]);
		int i;
		for (i = 0; i < set_words.size(); i++)
			send_word(set_words[i], i == set_words.size() - 1);
	endtask

	// Holds the sender off until every predicted word has been emitted. The
	// first edge lets the checker register the set that was just closed.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
	endtask

	// Mixes the extremes, words near either extreme, a narrow band that
	// yields many equal words, and full-range random words.
	function automatic word_t rand_word();
		case ($urandom_range(0, 9))
			0: return MIN_WORD;
			1: return PAD_WORD;
			2: return word_t'(int'($urandom_range(0, 8)) - 4);
			3: return PAD_WORD - word_t'($urandom_range(0, 3));
			4: return MIN_WORD + word_t'($urandom_range(0, 3));
			default: return word_t'($urandom());
		endcase
	endfunction

	// Most sets are small so that the run stays short; a few are larger.
	function automatic int rand_set_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 8);
		if (r < 95)
			return $urandom_range(9, 24);
		return $urandom_range(25, DEPTH);
	endfunction

	// The watchdog ends the run when nothing has moved for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((start && !busy) || out_valid))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL odd_even_transposition_sort_core");
		$finish;
	end

	initial begin : stimulus
		word_t set_words[$];
		int    items;
		int    set_no;
		int    size;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets. A single word of each extreme checks that the first
		// word can also be the last one and that padding never leaks out.
		set_words = '{MIN_WORD};
		send_set(set_words);
		set_words = '{PAD_WORD};
		send_set(set_words);
		// Both extremes mixed with words around zero; the copies of the
		// largest word must come out beside the padding, not be lost in it.
		set_words = '{PAD_WORD, MIN_WORD, 32'sd0, -32'sd1, 32'sd1, PAD_WORD, MIN_WORD};
		send_set(set_words);
		// Equal words never swap, so the sort ends after two quiet phases.
		set_words = '{32'sd5, 32'sd5, 32'sd5};
		send_set(set_words);
		// Descending order needs the most phases for its size.
		set_words = '{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2, -32'sd3, -32'sd4};
		send_set(set_words);
		// Already ascending: the very first phases are quiet.
		set_words = '{MIN_WORD, -32'sd1, 32'sd0, 32'sd1, PAD_WORD};
		send_set(set_words);
		wait_drained();

		// Random sets, with the idle rate changing every four sets. One set
		// fills the row exactly; another runs past it, so its extra words,
		// the last one among them, are dropped.
		items  = 0;
		set_no = 0;
		while (items < RANDOM_ITEMS) begin
			idle_pct = IDLE_PCT[(set_no / 4) % 4];
			if (set_no == 3)
				size = DEPTH;
			else if (set_no == 9)
				size = DEPTH + 3;
			else
				size = rand_set_size();
			set_words.delete();
			repeat (size) set_words.push_back(rand_word());
			send_set(set_words);
			items += size;
			if (set_no % 11 == 5)
				wait_drained();
			set_no++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && words_due == 0)
			$display("PASS odd_even_transposition_sort_core");
		else
			$display("FAIL odd_even_transposition_sort_core");
		$finish;
	end

endmodule

// ===== files.f =====
design/oets_pkg.sv
design/oets_cell.sv
design/odd_even_transposition_sort_core.sv
tb/sv/oets_sort_checker.sv
tb/sv/tb.sv
